// ===== design/ahdp_pkg.sv =====
`default_nettype none
package ahdp_pkg;

    localparam int unsigned VALUE_W = 64;

    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_LO_A   = 8'h61;
    localparam logic [7:0] CHAR_LO_F   = 8'h66;
    localparam logic [7:0] CHAR_UP_A   = 8'h41;
    localparam logic [7:0] CHAR_UP_F   = 8'h46;
    localparam logic [7:0] CHAR_LO_X   = 8'h78;
    localparam logic [7:0] CHAR_UP_X   = 8'h58;

    // Digit values run 0 to 15; NOT_DIGIT marks any other character.
    localparam logic [4:0] NOT_DIGIT   = 5'd16;
    localparam logic [4:0] DEC_BASE    = 5'd10;

    localparam logic [1:0] POS_FIRST   = 2'd0;
    localparam logic [1:0] POS_SECOND  = 2'd1;
    localparam logic [1:0] POS_LATER   = 2'd2;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               error;
    } t_result;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        begin
            v = 8'd0;
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                v = c - CHAR_ZERO;
            end else if (c >= CHAR_LO_A && c <= CHAR_LO_F) begin
                v = c - CHAR_LO_A + 8'd10;
            end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
                v = c - CHAR_UP_A + 8'd10;
            end else begin
                v = {3'd0, NOT_DIGIT};
            end
            return v[4:0];
        end
    endfunction

endpackage
`default_nettype wire

// ===== design/ahdp_in_stage.sv =====
`default_nettype none
module ahdp_in_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    output logic            o_valid,
    output logic [7:0]      o_byte,
    input  wire logic       i_take
);
    logic       r_valid;
    logic [7:0] r_byte;

    // The register frees up in the same cycle that its word moves on.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

endmodule
`default_nettype wire

// ===== design/ahdp_parse.sv =====
`default_nettype none
module ahdp_parse (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_res_room,
    output logic            o_take,
    output logic            o_res_valid,
    output ahdp_pkg::t_result o_res
);
    import ahdp_pkg::*;

    logic [1:0]         r_pos, n_pos;
    logic               r_lz, n_lz;
    logic               r_hex, n_hex;
    logic [VALUE_W-1:0] r_acc, n_acc;
    logic               r_ds, n_ds;
    logic               r_err, n_err;

    logic               is_end;
    logic               is_x;
    logic [4:0]         digit;
    logic               bad;
    logic [VALUE_W-1:0] scaled;
    logic               res_err;

    assign is_end = (i_byte == CHAR_NUL);
    assign is_x   = (i_byte == CHAR_LO_X) || (i_byte == CHAR_UP_X);
    assign digit  = hex_value(i_byte);
    assign bad    = r_hex ? (digit == NOT_DIGIT) : (digit >= DEC_BASE);

    // Times ten (decimal) is the sum of the value shifted by three and by one; hex shifts by four.
    assign scaled = r_hex ? {r_acc[VALUE_W-5:0], 4'd0}
                          : ({r_acc[VALUE_W-4:0], 3'd0} + {r_acc[VALUE_W-2:0], 1'b0});

    // A terminator waits only while the result register is still full.
    assign o_take      = i_valid && (!is_end || i_res_room);
    assign o_res_valid = o_take && is_end;
    assign res_err     = r_err || !r_ds;
    assign o_res.error = res_err;
    assign o_res.value = res_err ? '0 : r_acc;

    always_comb begin
        n_pos = r_pos;
        n_lz  = r_lz;
        n_hex = r_hex;
        n_acc = r_acc;
        n_ds  = r_ds;
        n_err = r_err;
        if (o_take) begin
            if (is_end) begin
                n_pos = POS_FIRST;
                n_lz  = 1'b0;
                n_hex = 1'b0;
                n_acc = '0;
                n_ds  = 1'b0;
                n_err = 1'b0;
            end else begin
                if (r_pos != POS_LATER) begin
                    n_pos = r_pos + 2'd1;
                end
                if (!r_err) begin
                    if (r_pos == POS_SECOND && r_lz && is_x) begin
                        n_hex = 1'b1;
                        n_acc = '0;
                        n_ds  = 1'b0;
                    end else begin
                        if (r_pos == POS_FIRST && i_byte == CHAR_ZERO) begin
                            n_lz = 1'b1;
                        end
                        if (bad) begin
                            n_err = 1'b1;
                        end else begin
                            n_acc = scaled + {{(VALUE_W-5){1'b0}}, digit};
                            n_ds  = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_FIRST;
            r_lz  <= 1'b0;
            r_hex <= 1'b0;
            r_acc <= '0;
            r_ds  <= 1'b0;
            r_err <= 1'b0;
        end else begin
            r_pos <= n_pos;
            r_lz  <= n_lz;
            r_hex <= n_hex;
            r_acc <= n_acc;
            r_ds  <= n_ds;
            r_err <= n_err;
        end
    end

    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_pos == POS_FIRST) && !r_hex && !r_ds && !r_err && (r_acc == '0))
        else $error("parser state not cleared after terminator");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.error) |-> (o_res.value == '0))
        else $error("error result carries a nonzero value");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos != 2'd3)
        else $error("character position out of range");

    a_hex_needs_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hex |-> (r_lz && r_pos != POS_FIRST))
        else $error("hex mode without a leading zero");

endmodule
`default_nettype wire

// ===== design/ahdp_out_stage.sv =====
`default_nettype none
module ahdp_out_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire ahdp_pkg::t_result i_res,
    output logic                   o_room,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output ahdp_pkg::t_result      o_res
);
    import ahdp_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_room  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_room)
        else $error("result register loaded while still full");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> r_valid && $stable(r_res))
        else $error("stalled result word changed");

endmodule
`default_nettype wire

// ===== design/ascii_u64_hex_or_decimal_parser_core.sv =====
// Channel  Direction  Handshake                   Word
// -------  ---------  --------------------------  -------------------------------------
// in       input      i_in_valid / o_in_ready     i_char_byte
// out      output     o_out_valid / i_out_ready   o_parsed_value, o_parse_error
//
// A byte is taken every cycle unless a terminator is held back by a full output register; a
// terminator's result passes from the input register through the parser into the output register.
// The pace is set by the update of the 64-bit accumulator (shift and add), done in a single register.
// Reset is synchronous and active low; it clears all control state and the parse state.
// While a result waits in the output register, digits keep flowing; only a second
// terminator is held in the input register until the output register frees up.
`default_nettype none
module ascii_u64_hex_or_decimal_parser_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [7:0]                    i_char_byte,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [ahdp_pkg::VALUE_W-1:0]       o_parsed_value,
    output logic                               o_parse_error
);
    import ahdp_pkg::*;

    logic       byte_valid;
    logic [7:0] byte_word;
    logic       take;
    logic       res_room;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    ahdp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_byte  (i_char_byte),
        .o_valid (byte_valid),
        .o_byte  (byte_word),
        .i_take  (take)
    );

    ahdp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (byte_valid),
        .i_byte      (byte_word),
        .i_res_room  (res_room),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ahdp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .o_room  (res_room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (out_res)
    );

    assign o_parsed_value = out_res.value;
    assign o_parse_error  = out_res.error;

endmodule
`default_nettype wire

// ===== verif/parse_result_checker.sv =====
`timescale 1ns / 1ps
module parse_result_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic [7:0]                   i_char_byte,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [ahdp_pkg::VALUE_W-1:0] i_parsed_value,
    input  logic                         i_parse_error,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_results_checked
);
    import ahdp_pkg::*;

    localparam logic [4:0] HEX_BASE = 5'd16;

    // Shadow copy of the parse state.
    logic [1:0]         char_pos;
    logic               first_was_zero;
    logic               in_hex;
    logic               digits_counted;
    logic               string_bad;
    logic [VALUE_W-1:0] running_value;

    t_result expected_results[$];

    function automatic logic [4:0] digit_of(input logic [7:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            return 5'(c - CHAR_ZERO);
        end
        if (c >= CHAR_LO_A && c <= CHAR_LO_F) begin
            return 5'(c - CHAR_LO_A) + 5'd10;
        end
        if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
            return 5'(c - CHAR_UP_A) + 5'd10;
        end
        return NOT_DIGIT;
    endfunction

    function automatic void clear_parse();
        char_pos       = POS_FIRST;
        first_was_zero = 1'b0;
        in_hex         = 1'b0;
        digits_counted = 1'b0;
        string_bad     = 1'b0;
        running_value  = '0;
    endfunction

    function automatic void take_byte(input logic [7:0] c);
        t_result    res;
        logic [1:0] pos_now;
        logic [4:0] radix;
        logic [4:0] digit;
        pos_now = char_pos;
        if (c == CHAR_NUL) begin
            res.error = string_bad || !digits_counted;
            res.value = res.error ? '0 : running_value;
            expected_results.push_back(res);
            clear_parse();
            return;
        end
        if (char_pos != POS_LATER) begin
            char_pos = char_pos + 2'd1;
        end
        if (string_bad) begin
            return;
        end
        // An x right after a leading zero switches to base 16 and restarts the value.
        if (pos_now == POS_SECOND && first_was_zero && (c == CHAR_LO_X || c == CHAR_UP_X)) begin
            in_hex         = 1'b1;
            running_value  = '0;
            digits_counted = 1'b0;
            return;
        end
        if (pos_now == POS_FIRST && c == CHAR_ZERO) begin
            first_was_zero = 1'b1;
        end
        radix = in_hex ? HEX_BASE : DEC_BASE;
        digit = digit_of(c);
        if (digit >= radix) begin
            string_bad = 1'b1;
        end else begin
            running_value  = running_value * 64'(radix) + 64'(digit);
            digits_counted = 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_parse();
            expected_results.delete();
            o_fail_count      = 0;
            o_results_checked = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_results_checked++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result word: parsed_value %h, parse_error %b",
                           i_parsed_value, i_parse_error);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_parsed_value !== want.value) begin
                        $error("parsed_value: expected %h, actual %h", want.value, i_parsed_value);
                        o_fail_count++;
                    end
                    if (i_parse_error !== want.error) begin
                        $error("parse_error: expected %b, actual %b", want.error, i_parse_error);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                take_byte(i_char_byte);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== verif/tb_ascii_u64_hex_or_decimal_parser_core.sv =====
`timescale 1ns / 1ps
module tb_ascii_u64_hex_or_decimal_parser_core;
    import ahdp_pkg::*;

    localparam int RANDOM_BYTES = 1550;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 20;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_MOSTLY,
        RDY_PATTERN
    } t_ready_mode;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [7:0]         i_char_byte;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [VALUE_W-1:0] o_parsed_value;
    logic               o_parse_error;

    int fail_count;
    int pending_results;
    int results_checked;
    int hold_requests = 0;
    int bytes_sent    = 0;
    int strings_sent  = 0;
    int burst_left    = 0;

    logic [7:0] text_q[$];

    ascii_u64_hex_or_decimal_parser_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_char_byte    (i_char_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_parsed_value (o_parsed_value),
        .o_parse_error  (o_parse_error)
    );

    parse_result_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_char_byte       (i_char_byte),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_parsed_value    (o_parsed_value),
        .i_parse_error     (o_parse_error),
        .o_fail_count      (fail_count),
        .o_pending         (pending_results),
        .o_results_checked (results_checked)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Result side: changing stall styles, plus a long hold whenever one is requested.
    initial begin
        t_ready_mode mode;
        int          mode_left;
        int          holds_served;
        logic [7:0]  ready_bits;
        mode_left    = 0;
        holds_served = 0;
        ready_bits   = 8'hFF;
        mode         = RDY_ALWAYS;
        i_out_ready  = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served++;
                i_out_ready <= 1'b0;
                for (int held = 0; held < LONG_HOLD; held++) begin
                    @(negedge i_clk);
                end
            end else begin
                if (mode_left == 0) begin
                    mode       = t_ready_mode'($urandom_range(0, 3));
                    mode_left  = $urandom_range(20, 300);
                    ready_bits = 8'($urandom_range(1, 255));
                end
                mode_left--;
                case (mode)
                    RDY_ALWAYS: begin
                        i_out_ready <= 1'b1;
                    end
                    RDY_COIN: begin
                        i_out_ready <= 1'($urandom_range(0, 1));
                    end
                    RDY_MOSTLY: begin
                        i_out_ready <= ($urandom_range(0, 9) != 0);
                    end
                    default: begin
                        i_out_ready <= ready_bits[0];
                        ready_bits = {ready_bits[0], ready_bits[7:1]};
                    end
                endcase
            end
        end
    end

    // Offers one word; bursts of random length are separated by random gaps.
    task automatic feed_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_char_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_text();
        foreach (text_q[k]) begin
            feed_byte(text_q[k]);
        end
        feed_byte(CHAR_NUL);
        strings_sent++;
        text_q.delete();
    endtask

    task automatic send_literal(input string s);
        for (int k = 0; k < s.len(); k++) begin
            text_q.push_back(s[k]);
        end
        send_text();
    endtask

    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_results != 0) @(negedge i_clk);
    endtask

    function automatic logic [7:0] rand_dec_char();
        return CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_hex_char();
        logic [7:0] v;
        v = 8'($urandom_range(0, 15));
        if (v < 8'd10) begin
            return CHAR_ZERO + v;
        end
        return (($urandom_range(0, 1) == 0) ? CHAR_LO_A : CHAR_UP_A) + v - 8'd10;
    endfunction

    function automatic void push_decimal();
        int n;
        string top_val;
        if ($urandom_range(0, 19) == 0) begin
            // Largest 64-bit value, or one past it, which wraps to zero.
            top_val = ($urandom_range(0, 1) == 0) ? "18446744073709551615"
                                                  : "18446744073709551616";
            for (int k = 0; k < top_val.len(); k++) begin
                text_q.push_back(top_val[k]);
            end
            return;
        end
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 24) : $urandom_range(1, 8);
        repeat (n) text_q.push_back(rand_dec_char());
    endfunction

    function automatic void push_hex();
        int n;
        text_q.push_back(CHAR_ZERO);
        text_q.push_back(($urandom_range(0, 1) == 0) ? CHAR_LO_X : CHAR_UP_X);
        case ($urandom_range(0, 9))
            0:       n = 0;
            1:       n = $urandom_range(16, 20);
            default: n = $urandom_range(1, 8);
        endcase
        repeat (n) text_q.push_back(rand_hex_char());
    endfunction

    function automatic void build_random_text();
        int         pick;
        logic [7:0] bad;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            push_decimal();
        end else if (pick < 75) begin
            push_hex();
        end else if (pick < 87) begin
            if ($urandom_range(0, 1) == 0) begin
                push_decimal();
            end else begin
                push_hex();
            end
            case ($urandom_range(0, 3))
                0:       bad = CHAR_LO_X;
                1:       bad = CHAR_UP_X;
                2:       bad = 8'($urandom_range(1, 255));
                default: bad = 8'($urandom_range(128, 255));
            endcase
            text_q.insert($urandom_range(0, text_q.size()), bad);
        end else if (pick < 95) begin
            repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(1, 255)));
        end
        // The rest stay empty: a bare terminator.
    endfunction

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_char_byte = 8'h00;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_literal("");
        send_literal("0x");
        send_literal("0XfF");
        send_literal("9");
        send_literal("00");
        send_literal("x5");
        send_literal("12a");
        text_q.push_back(8'hFF);
        text_q.push_back(8'h01);
        send_text();

        while (bytes_sent < RANDOM_BYTES) begin
            if (strings_sent == 40) begin
                // Hold the result side off while short strings keep coming, so the
                // block fills and must stall its input.
                hold_requests <= hold_requests + 1;
                burst_left = 1000;
                repeat (30) begin
                    text_q.push_back(rand_dec_char());
                    send_text();
                end
                burst_left = 0;
            end
            if (strings_sent == 100 || strings_sent == 180) begin
                wait_all_results();
            end
            build_random_text();
            send_text();
        end
        i_in_valid <= 1'b0;

        while (pending_results != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Run covered %0d strings in %0d words: prefix and base cases, overflow, bad",
                 strings_sent, bytes_sent);
        $display("characters, noise, a long result stall; %0d results compared, %0d failures.",
                 results_checked, fail_count);
        if (fail_count == 0 && pending_results == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
